@@ sv/khr_pkg.sv @@
// shared constants, types and lookup functions for the hid keyboard report unit
package khr_pkg;

  localparam int unsigned MaxHeldKeysDefault = 6;
  localparam int unsigned KeySlots           = 6;
  localparam int unsigned RomSize            = 195;

  localparam int unsigned TypeW  = 5;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned ByteW  = 8;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 56;

  localparam logic [TypeW-1:0]  EvSync     = 5'd0;
  localparam logic [TypeW-1:0]  EvKey      = 5'd1;
  localparam logic [CodeW-1:0]  SynReport  = 16'd0;
  localparam logic [ValueW-1:0] ValRelease = 32'd0;
  localparam logic [ValueW-1:0] ValPress   = 32'd1;

  localparam logic [ByteW-1:0] UsageRom [RomSize] = '{
    8'h00, 8'h29, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25,
    8'h26, 8'h27, 8'h2d, 8'h2e, 8'h2a, 8'h2b, 8'h14, 8'h1a, 8'h08, 8'h15,
    8'h17, 8'h1c, 8'h18, 8'h0c, 8'h12, 8'h13, 8'h2f, 8'h30, 8'h28, 8'h00,
    8'h04, 8'h16, 8'h07, 8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h33,
    8'h34, 8'h35, 8'h00, 8'h32, 8'h1d, 8'h1b, 8'h06, 8'h19, 8'h05, 8'h11,
    8'h10, 8'h36, 8'h37, 8'h38, 8'h00, 8'h55, 8'h00, 8'h2c, 8'h39, 8'h3a,
    8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53,
    8'h47, 8'h5f, 8'h60, 8'h61, 8'h56, 8'h5c, 8'h5d, 8'h5e, 8'h57, 8'h59,
    8'h5a, 8'h5b, 8'h62, 8'h63, 8'h00, 8'h94, 8'h64, 8'h44, 8'h45, 8'h87,
    8'h92, 8'h93, 8'h8a, 8'h88, 8'h8b, 8'h8c, 8'h58, 8'h00, 8'h54, 8'h46,
    8'h00, 8'h00, 8'h4a, 8'h52, 8'h4b, 8'h50, 8'h4f, 8'h4d, 8'h51, 8'h4e,
    8'h49, 8'h4c, 8'h00, 8'h7f, 8'h81, 8'h80, 8'h66, 8'h67, 8'h00, 8'h48,
    8'h00, 8'h85, 8'h90, 8'h91, 8'h89, 8'h00, 8'h00, 8'h65, 8'h78, 8'h79,
    8'h76, 8'h7a, 8'h77, 8'h7c, 8'h74, 8'h7d, 8'h7e, 8'h7b, 8'h75, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e,
    8'h6f, 8'h70, 8'h71, 8'h72, 8'h73
  };

  typedef struct packed {
    logic             press;
    logic             release_key;
    logic [ByteW-1:0] code;
    logic [ByteW-1:0] usage;
  } list_cmd_t;

  function automatic logic [ByteW-1:0] usage_lookup(input logic [ByteW-1:0] code);
    logic [ByteW-1:0] usage;
    usage = '0;
    if (int'(code) < RomSize) begin
      usage = UsageRom[code];
    end
    return usage;
  endfunction

  function automatic logic [ByteW-1:0] modifier_mask(input logic [CodeW-1:0] code);
    logic [ByteW-1:0] mask;
    case (code)
      16'd29:  mask = 8'h01;
      16'd42:  mask = 8'h02;
      16'd56:  mask = 8'h04;
      16'd125: mask = 8'h08;
      16'd97:  mask = 8'h10;
      16'd54:  mask = 8'h20;
      16'd100: mask = 8'h40;
      16'd126: mask = 8'h80;
      default: mask = 8'h00;
    endcase
    return mask;
  endfunction

endpackage

@@ sv/khr_key_list.sv @@
// ordered list of held normal keys with append on press and close-up on release
module khr_key_list #(
  parameter int unsigned MaxHeldKeys = khr_pkg::MaxHeldKeysDefault,
  parameter int unsigned CntW        = $clog2(MaxHeldKeys + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  khr_pkg::list_cmd_t         cmd_i,
  output logic [khr_pkg::ByteW-1:0]  slots_o [khr_pkg::KeySlots],
  output logic [CntW-1:0]            count_o
);

  logic [khr_pkg::ByteW-1:0] codes_q [MaxHeldKeys];
  logic [khr_pkg::ByteW-1:0] codes_d [MaxHeldKeys];
  logic [khr_pkg::ByteW-1:0] usage_q [MaxHeldKeys];
  logic [khr_pkg::ByteW-1:0] usage_d [MaxHeldKeys];
  logic [CntW-1:0]           count_q, count_d;
  logic [MaxHeldKeys-1:0]    match;
  logic [MaxHeldKeys-1:0]    shift;
  logic                      hit;

  always_comb begin
    for (int j = 0; j < MaxHeldKeys; j++) begin
      match[j] = (count_q > CntW'(j)) && (codes_q[j] == cmd_i.code);
    end
    hit = |match;
    shift[0] = match[0];
    for (int j = 1; j < MaxHeldKeys; j++) begin
      shift[j] = shift[j-1] | match[j];
    end
  end

  always_comb begin
    codes_d = codes_q;
    usage_d = usage_q;
    count_d = count_q;
    if (cmd_valid_i && cmd_i.press && !hit && (count_q < CntW'(MaxHeldKeys))) begin
      for (int j = 0; j < MaxHeldKeys; j++) begin
        if (count_q == CntW'(j)) begin
          codes_d[j] = cmd_i.code;
          usage_d[j] = cmd_i.usage;
        end
      end
      count_d = count_q + CntW'(1);
    end else if (cmd_valid_i && cmd_i.release_key && hit) begin
      for (int j = 0; j < MaxHeldKeys - 1; j++) begin
        if (shift[j]) begin
          codes_d[j] = codes_q[j+1];
          usage_d[j] = usage_q[j+1];
        end
      end
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    codes_q <= codes_d;
    usage_q <= usage_d;
  end

  for (genvar k = 0; k < khr_pkg::KeySlots; k++) begin : g_slot
    if (k < MaxHeldKeys) begin : g_held
      assign slots_o[k] = (count_q > CntW'(k)) ? usage_q[k] : '0;
    end else begin : g_none
      assign slots_o[k] = '0;
    end
  end

  assign count_o = count_q;

endmodule

@@ sv/key_event_to_hid_keyboard_report_unit.sv @@
// top level: key event stream in, hid boot keyboard report stream out
// Takes one input event per beat and produces a 7-byte boot keyboard report
// (reserved byte left out) on each report sync that follows a key press or
// release. An event is registered on acceptance and decoded in the next cycle,
// where the modifier byte and the held-key list are updated and any report is
// loaded into the output register once that register is free, and a new event
// is taken every cycle while no decoded event waits. Only an event that
// produces a report waits, and only while the output register still holds an
// untaken report. Key repeats and unknown event types change nothing. Up to
// MAX_HELD_KEYS normal keys are held in press order; further presses, and
// presses of a key already held, are dropped.
module key_event_to_hid_keyboard_report_unit #(
  parameter int unsigned MAX_HELD_KEYS = khr_pkg::MaxHeldKeysDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // event_type [4:0], event_code [20:5], event_value [52:21], zero fill
  input  logic [khr_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // modifier_bits [7:0], key_slot_0 [15:8] up to key_slot_5 [55:48]
  output logic [khr_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned CntW = $clog2(MAX_HELD_KEYS + 1);

  logic                              in_valid_q;
  logic [khr_pkg::TypeW-1:0]         type_q;
  logic [khr_pkg::CodeW-1:0]         code_q;
  logic [khr_pkg::ValueW-1:0]        value_q;
  logic                              out_valid_q;
  logic [khr_pkg::OutDataW-1:0]      out_data_q;
  logic                              pending_q, pending_d;
  logic [khr_pkg::ByteW-1:0]         modifier_q, modifier_d;

  logic                              in_fire;
  logic                              is_report;
  logic                              is_key;
  logic                              is_press;
  logic                              emit;
  logic                              out_free;
  logic                              proc_fire;
  logic [khr_pkg::ByteW-1:0]         mask;
  logic                              in_table;
  logic                              list_en;
  khr_pkg::list_cmd_t                list_cmd;
  logic [khr_pkg::ByteW-1:0]         slots [khr_pkg::KeySlots];
  logic [CntW-1:0]                   held_count;
  logic [khr_pkg::OutDataW-1:0]      report;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !in_valid_q || proc_fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      type_q  <= s_axis_tdata[4:0];
      code_q  <= s_axis_tdata[20:5];
      value_q <= s_axis_tdata[52:21];
    end
  end

  // decode
  assign is_report = (type_q == khr_pkg::EvSync) && (code_q == khr_pkg::SynReport) &&
                     (value_q == khr_pkg::ValRelease);
  assign is_press  = (value_q == khr_pkg::ValPress);
  assign is_key    = (type_q == khr_pkg::EvKey) &&
                     ((value_q == khr_pkg::ValRelease) || is_press);
  assign emit      = is_report && pending_q;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign proc_fire = in_valid_q && (!emit || out_free);
  assign mask      = khr_pkg::modifier_mask(code_q);
  assign in_table  = (code_q < khr_pkg::CodeW'(khr_pkg::RomSize));

  always_comb begin
    pending_d  = pending_q;
    modifier_d = modifier_q;
    list_en    = 1'b0;
    if (proc_fire && is_key) begin
      pending_d = 1'b1;
      if (mask != '0) begin
        modifier_d = is_press ? (modifier_q | mask) : (modifier_q & ~mask);
      end else begin
        list_en = in_table;
      end
    end else if (proc_fire && emit) begin
      pending_d = 1'b0;
    end
  end

  assign list_cmd.press       = is_press;
  assign list_cmd.release_key = !is_press;
  assign list_cmd.code        = code_q[khr_pkg::ByteW-1:0];
  assign list_cmd.usage       = khr_pkg::usage_lookup(code_q[khr_pkg::ByteW-1:0]);

  khr_key_list #(
    .MaxHeldKeys (MAX_HELD_KEYS),
    .CntW        (CntW)
  ) u_key_list (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (list_en),
    .cmd_i       (list_cmd),
    .slots_o     (slots),
    .count_o     (held_count)
  );

  assign report = {slots[5], slots[4], slots[3], slots[2], slots[1], slots[0], modifier_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      modifier_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pending_q  <= pending_d;
      modifier_q <= modifier_d;
      if (proc_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (proc_fire && emit) begin
      out_data_q <= report;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count <= CntW'(MAX_HELD_KEYS))
    else $error("held key count beyond list depth");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && emit |=> !pending_q && out_valid_q)
    else $error("report beat did not clear pending flag");

  a_key_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && is_key |=> pending_q)
    else $error("key event did not mark report pending");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("empty input register not ready");
`endif

endmodule
